[sv/ctm_pkg.sv]
// Shared types, codes and sizes for the time coincidence merge table.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ctm_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W       = ((CNT_W > 6) ? CNT_W : 6) + 1;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_MERGED  = 3'd0,
    ST_NEW_CAP = 3'd1,
    ST_NEW_ELE = 3'd2,
    ST_IGNORED = 3'd3,
    ST_FULL    = 3'd4,
    ST_READ    = 3'd5,
    ST_CLEARED = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RDWAIT,
    S_EMIT
  } state_e;

  localparam logic [2:0] CFG_WINDOW   = 3'd0;
  localparam logic [2:0] CFG_CAPTURE  = 3'd1;
  localparam logic [2:0] CFG_DECAY    = 3'd2;
  localparam logic [2:0] CFG_GAMMA    = 3'd3;
  localparam logic [2:0] CFG_ELECTRON = 3'd4;

  localparam logic KIND_CAPTURE  = 1'b0;
  localparam logic KIND_ELECTRON = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         interaction_code;
    logic signed [15:0] particle_code;
    logic [39:0]        hit_time;
    logic [23:0]        hit_energy;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [5:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         entry_slot;
    logic [6:0]         match_count;
    logic               entry_kind;
    logic [39:0]        entry_time;
    logic [23:0]        entry_energy;
    logic signed [15:0] entry_x;
    logic signed [15:0] entry_y;
    logic signed [15:0] entry_z;
    logic [6:0]         entry_total;
  } out_item_t;

  typedef struct packed {
    logic        kind;
    logic [39:0] ent_time;
    logic [23:0] energy;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } ctm_entry_t;

  typedef struct packed {
    logic             ren;
    logic [IDX_W-1:0] raddr;
    logic             wen;
    logic [IDX_W-1:0] waddr;
    ctm_entry_t       wdata;
  } ctm_mem_req_t;

endpackage

[sv/ctm_mem.sv]
// Entry store of the merge table: one write port, one registered read port.
// Depends on ctm_pkg for the entry record and the request struct.
`timescale 1ns / 1ps

module ctm_mem import ctm_pkg::*; (
  input  logic         clk_i,
  input  ctm_mem_req_t req_i,
  output ctm_entry_t   rdata_o
);

  ctm_entry_t mem_q [MAX_ENTRIES];
  ctm_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wen) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.ren) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/ctm_match.sv]
// Shared compare unit: time distance against the window, saturating energy sum.
// Depends on ctm_pkg for the entry record.
`timescale 1ns / 1ps

module ctm_match import ctm_pkg::*; (
  input  logic [39:0] hit_time_i,
  input  logic [23:0] hit_energy_i,
  input  logic [15:0] window_i,
  input  ctm_entry_t  entry_i,
  output logic        hit_o,
  output logic [23:0] energy_sum_o
);

  logic [40:0] diff;
  logic [39:0] gap;
  logic [24:0] sum;

  assign diff = {1'b0, hit_time_i} - {1'b0, entry_i.ent_time};
  // negative difference: take the magnitude
  assign gap = diff[40] ? (~diff[39:0] + 40'd1) : diff[39:0];
  assign hit_o = gap < {24'd0, window_i};

  assign sum = {1'b0, entry_i.energy} + {1'b0, hit_energy_i};
  assign energy_sum_o = sum[24] ? 24'hFFFFFF : sum[23:0];

endmodule

[sv/time_coincidence_merge_table.sv]
// Top level of the time coincidence merge table: sequencer, fill count, config.
// Depends on ctm_pkg, ctm_mem and ctm_match.
`timescale 1ns / 1ps

// One transaction at a time. A capture gamma walks the table one entry per
// cycle through the single compare unit and memory read port, merging its
// energy into every entry within the window, and is appended as a new
// entry when none matches. The result sits in an output register, so the
// next transaction is taken while it waits to be collected.
// Configuration writes land at once and are meant for idle periods only.
module time_coincidence_merge_table import ctm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  logic [15:0] window_q;
  logic [7:0]  capture_q;
  logic [7:0]  decay_q;
  logic [14:0] gamma_q;
  logic [14:0] electron_q;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic [IDX_W-1:0] first_q, first_d;
  ctm_entry_t       first_ent_q, first_ent_d;
  in_item_t         item_q, item_d;
  out_item_t        res_q, res_d;
  out_item_t        out_q;
  logic             out_valid_q;

  ctm_mem_req_t mem_req;
  ctm_entry_t   rdata;
  ctm_entry_t   upd_ent;
  ctm_entry_t   app_ent;
  in_item_t     app_src;
  logic         app_kind;
  logic         do_append;
  logic         app_full;
  logic         accept;
  logic         is_gamma;
  logic         is_elec;
  logic [15:0]  mag;
  logic         issue;
  logic         hit;
  logic [23:0]  energy_sum;
  logic         rd_in_range;
  logic         emit_go;

  function automatic out_item_t put_entry(out_item_t r, ctm_entry_t e);
    out_item_t o;
    o              = r;
    o.entry_kind   = e.kind;
    o.entry_time   = e.ent_time;
    o.entry_energy = e.energy;
    o.entry_x      = e.x;
    o.entry_y      = e.y;
    o.entry_z      = e.z;
    return o;
  endfunction

  ctm_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  ctm_match u_match (
    .hit_time_i   (item_q.hit_time),
    .hit_energy_i (item_q.hit_energy),
    .window_i     (window_q),
    .entry_i      (rdata),
    .hit_o        (hit),
    .energy_sum_o (energy_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= 16'd10;
      capture_q  <= 8'd18;
      decay_q    <= 8'd5;
      gamma_q    <= 15'd22;
      electron_q <= 15'd11;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW:   window_q   <= cfg_wdata_i;
        CFG_CAPTURE:  capture_q  <= cfg_wdata_i[7:0];
        CFG_DECAY:    decay_q    <= cfg_wdata_i[7:0];
        CFG_GAMMA:    gamma_q    <= cfg_wdata_i[14:0];
        CFG_ELECTRON: electron_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign mag      = in_data_i.particle_code[15] ? 16'(-in_data_i.particle_code)
                                                : in_data_i.particle_code;
  assign is_gamma = (in_data_i.interaction_code == capture_q) &&
                    !in_data_i.particle_code[15] &&
                    (in_data_i.particle_code[14:0] == gamma_q);
  // the most negative code has bit 15 set in its magnitude and never matches
  assign is_elec  = (in_data_i.interaction_code == decay_q) &&
                    (mag == {1'b0, electron_q});

  assign issue       = (rd_ptr_q != fill_q);
  assign app_full    = (fill_q == CNT_W'(MAX_ENTRIES));
  assign rd_in_range = CMP_W'(item_q.read_index) < CMP_W'(fill_q);
  assign app_src     = (state_q == S_IDLE) ? in_data_i : item_q;
  assign emit_go     = !out_valid_q || out_ready_i;

  always_comb begin
    upd_ent        = rdata;
    upd_ent.energy = energy_sum;
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rd_ptr_d    = rd_ptr_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    first_d     = first_q;
    first_ent_d = first_ent_q;
    item_d      = item_q;
    res_d       = res_q;
    mem_req     = '0;
    do_append   = 1'b0;
    app_kind    = KIND_CAPTURE;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d             = in_data_i;
          res_d              = '0;
          res_d.status       = ST_IGNORED;
          res_d.entry_total  = 7'(fill_q);
          state_d            = S_EMIT;
          case (cmd_e'(in_data_i.command))
            CMD_ADD: begin
              if (is_gamma) begin
                if (fill_q != '0) begin
                  state_d  = S_SCAN;
                  rd_ptr_d = '0;
                  cnt_d    = '0;
                end else begin
                  do_append = 1'b1;
                  app_kind  = KIND_CAPTURE;
                end
              end else if (is_elec) begin
                do_append = 1'b1;
                app_kind  = KIND_ELECTRON;
              end
            end
            CMD_READ: begin
              mem_req.ren   = 1'b1;
              mem_req.raddr = IDX_W'(in_data_i.read_index);
              state_d       = S_RDWAIT;
            end
            CMD_CLEAR: begin
              fill_d            = '0;
              res_d.status      = ST_CLEARED;
              res_d.entry_total = '0;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // read one entry ahead while the previous one is compared
        if (issue) begin
          mem_req.ren   = 1'b1;
          mem_req.raddr = IDX_W'(rd_ptr_q);
          rd_ptr_d      = rd_ptr_q + CNT_W'(1);
          pend_d        = 1'b1;
          pend_idx_d    = IDX_W'(rd_ptr_q);
        end
        if (pend_q && hit) begin
          mem_req.wen   = 1'b1;
          mem_req.waddr = pend_idx_q;
          mem_req.wdata = upd_ent;
          cnt_d         = cnt_q + CNT_W'(1);
          if (cnt_q == '0) begin
            first_d     = pend_idx_q;
            first_ent_d = upd_ent;
          end
        end
        if (!issue && !pend_q) begin
          res_d             = '0;
          res_d.entry_total = 7'(fill_q);
          state_d           = S_EMIT;
          if (cnt_q != '0) begin
            res_d             = put_entry(res_d, first_ent_q);
            res_d.status      = ST_MERGED;
            res_d.entry_slot  = 6'(first_q);
            res_d.match_count = 7'(cnt_q);
          end else begin
            do_append = 1'b1;
            app_kind  = KIND_CAPTURE;
          end
        end
      end

      S_RDWAIT: begin
        res_d             = '0;
        res_d.status      = ST_READ;
        res_d.entry_slot  = item_q.read_index;
        res_d.entry_total = 7'(fill_q);
        if (rd_in_range) begin
          res_d = put_entry(res_d, rdata);
        end
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (emit_go) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    app_ent.kind     = app_kind;
    app_ent.ent_time = app_src.hit_time;
    app_ent.energy   = app_src.hit_energy;
    app_ent.x        = app_src.pos_x;
    app_ent.y        = app_src.pos_y;
    app_ent.z        = app_src.pos_z;

    if (do_append) begin
      if (app_full) begin
        res_d.status = ST_FULL;
      end else begin
        mem_req.wen       = 1'b1;
        mem_req.waddr     = IDX_W'(fill_q);
        mem_req.wdata     = app_ent;
        fill_d            = fill_q + CNT_W'(1);
        res_d             = put_entry(res_d, app_ent);
        res_d.status      = (app_kind == KIND_ELECTRON) ? ST_NEW_ELE : ST_NEW_CAP;
        res_d.entry_slot  = 6'(fill_q);
        res_d.entry_total = 7'(fill_q + CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      if (state_q == S_EMIT && emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= pend_idx_d;
    first_q     <= first_d;
    first_ent_q <= first_ent_d;
    item_q      <= item_d;
    res_q       <= res_d;
    if (state_q == S_EMIT && emit_go) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/ctm_checker.sv]
// Port-level checks of the merge table, bound to the top level.
// Depends on ctm_pkg and time_coincidence_merge_table.
`timescale 1ns / 1ps

module ctm_checker import ctm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_item_t   out_data_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one transaction at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a transaction is in work");

  a_count_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_MERGED |-> out_data_o.match_count == 7'd0)
    else $error("match count set on a result that merged nothing");

  a_clear_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_CLEARED |-> out_data_o.entry_total == 7'd0)
    else $error("table not empty after clear");

  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |->
      out_data_o.entry_total == 7'(MAX_ENTRIES) && out_data_o.entry_energy == 24'd0)
    else $error("full result with a table that is not full");

endmodule

bind time_coincidence_merge_table ctm_checker u_ctm_checker (.*);

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench for time_coincidence_merge_table: directed and random particle records
// checked field by field against a behavioral model of the event table.
// Depends on ctm_pkg and the time_coincidence_merge_table RTL.

module tb;
  import ctm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int PRINT_CAP   = 100;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = CFG_WINDOW;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;

  // Behavioral copy of the table and its registers
  ctm_entry_t  event_rows [MAX_ENTRIES];
  int          rows_held = 0;
  logic [15:0] win_cfg   = 16'd10;
  logic [7:0]  cap_cfg   = 8'd18;
  logic [7:0]  dec_cfg   = 8'd5;
  logic [14:0] gam_cfg   = 15'd22;
  logic [14:0] ele_cfg   = 15'd11;

  in_item_t    particle_queue [$];
  out_item_t   report_queue [$];
  out_item_t   head_report;
  logic [39:0] recent_stamps [$];
  logic [39:0] gen_base = '0;
  int unsigned gen_span = 64;

  int items_queued = 0;
  int reports_seen = 0;
  int fault_count  = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int send_wait    = 0;
  int send_calm    = 0;
  int recv_wait    = 0;
  int recv_calm    = 0;
  int recv_hold    = 0;
  int cycle_count  = 0;

  time_coincidence_merge_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic out_item_t entry_report(out_item_t rep, int idx);
    rep.entry_kind   = event_rows[idx].kind;
    rep.entry_time   = event_rows[idx].ent_time;
    rep.entry_energy = event_rows[idx].energy;
    rep.entry_x      = event_rows[idx].x;
    rep.entry_y      = event_rows[idx].y;
    rep.entry_z      = event_rows[idx].z;
    return rep;
  endfunction

  function automatic out_item_t append_row(logic kind, in_item_t rec);
    out_item_t rep;
    rep = '0;
    if (rows_held >= MAX_ENTRIES) begin
      rep.status = ST_FULL;
      return rep;
    end
    event_rows[rows_held].kind     = kind;
    event_rows[rows_held].ent_time = rec.hit_time;
    event_rows[rows_held].energy   = rec.hit_energy;
    event_rows[rows_held].x        = rec.pos_x;
    event_rows[rows_held].y        = rec.pos_y;
    event_rows[rows_held].z        = rec.pos_z;
    rep.status     = (kind == KIND_ELECTRON) ? ST_NEW_ELE : ST_NEW_CAP;
    rep.entry_slot = 6'(rows_held);
    rep            = entry_report(rep, rows_held);
    rows_held++;
    return rep;
  endfunction

  // Apply one transaction to the table copy and return the report it produces
  function automatic out_item_t table_update(in_item_t rec);
    out_item_t   rep;
    int          pid;
    int          mag;
    int          hits;
    int          first_hit;
    int          i;
    logic [39:0] dt;
    logic [24:0] sum;
    rep        = '0;
    rep.status = ST_IGNORED;
    hits       = 0;
    first_hit  = 0;
    case (cmd_e'(rec.command))
      CMD_ADD: begin
        pid = $signed(rec.particle_code);
        mag = (pid < 0) ? -pid : pid;
        if (rec.interaction_code == cap_cfg && pid == int'(gam_cfg)) begin
          // every held row is a candidate, electron rows too
          for (i = 0; i < rows_held; i++) begin
            dt = (rec.hit_time >= event_rows[i].ent_time) ?
                 rec.hit_time - event_rows[i].ent_time :
                 event_rows[i].ent_time - rec.hit_time;
            if (dt < 40'(win_cfg)) begin
              sum = {1'b0, event_rows[i].energy} + {1'b0, rec.hit_energy};
              event_rows[i].energy = sum[24] ? 24'hFFFFFF : sum[23:0];
              if (hits == 0) first_hit = i;
              hits++;
            end
          end
          if (hits > 0) begin
            rep.status      = ST_MERGED;
            rep.entry_slot  = 6'(first_hit);
            rep.match_count = 7'(hits);
            rep             = entry_report(rep, first_hit);
          end else begin
            rep = append_row(KIND_CAPTURE, rec);
          end
        end else if (rec.interaction_code == dec_cfg && mag == int'(ele_cfg)) begin
          rep = append_row(KIND_ELECTRON, rec);
        end
      end
      CMD_READ: begin
        rep.status     = ST_READ;
        rep.entry_slot = rec.read_index;
        if (int'(rec.read_index) < rows_held) rep = entry_report(rep, int'(rec.read_index));
      end
      CMD_CLEAR: begin
        rows_held  = 0;
        rep.status = ST_CLEARED;
      end
      default: ;
    endcase
    rep.entry_total = 7'(rows_held);
    return rep;
  endfunction

  task automatic field_check(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= PRINT_CAP)
        $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  function automatic in_item_t particle_item(logic [7:0] inter, logic [15:0] pid,
                                             logic [39:0] stamp, logic [23:0] energy);
    in_item_t rec;
    rec.command          = CMD_ADD;
    rec.interaction_code = inter;
    rec.particle_code    = pid;
    rec.hit_time         = stamp;
    rec.hit_energy       = energy;
    rec.pos_x            = 16'($urandom);
    rec.pos_y            = 16'($urandom);
    rec.pos_z            = 16'($urandom);
    rec.read_index       = 6'($urandom);
    return rec;
  endfunction

  function automatic in_item_t command_item(cmd_e cmd, logic [5:0] idx);
    in_item_t rec;
    rec            = '0;
    rec.command    = cmd;
    rec.read_index = idx;
    return rec;
  endfunction

  function automatic logic [23:0] energy_draw();
    if ($urandom_range(0, 3) == 0) return 24'($urandom_range(24'hF00000, 24'hFFFFFF));
    return 24'($urandom_range(0, 4095));
  endfunction

  // Land close to a recent particle time, on either side of the window edge
  function automatic logic [39:0] near_stamp(logic [39:0] fallback);
    int unsigned spread;
    if (recent_stamps.size() == 0) return fallback;
    spread = 2 * 32'(win_cfg) + 2;
    return recent_stamps[$urandom_range(0, recent_stamps.size() - 1)]
           + 40'($urandom_range(0, spread)) - 40'(win_cfg) - 40'd1;
  endfunction

  function automatic in_item_t random_item(int unsigned clear_pm);
    in_item_t     rec;
    logic [159:0] noise;
    int unsigned  roll;
    int           pid;
    logic [39:0]  stamp;
    roll  = $urandom_range(0, 999);
    stamp = gen_base + 40'($urandom_range(0, gen_span));
    if (roll < clear_pm) begin
      rec = command_item(CMD_CLEAR, 6'($urandom_range(0, 63)));
    end else if (roll < 450) begin
      rec = particle_item(cap_cfg, {1'b0, gam_cfg}, near_stamp(stamp), energy_draw());
    end else if (roll < 580) begin
      rec = particle_item(cap_cfg, {1'b0, gam_cfg}, stamp, energy_draw());
    end else if (roll < 720) begin
      pid = int'(ele_cfg);
      if ($urandom_range(0, 1) == 1) pid = -pid;
      if ($urandom_range(0, 1) == 1) stamp = near_stamp(stamp);
      rec = particle_item(dec_cfg, 16'(pid), stamp, energy_draw());
    end else if (roll < 830) begin
      rec = command_item(CMD_READ, ($urandom_range(0, 1) == 1) ?
                         6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63)));
    end else if (roll < 900) begin
      // almost a capture gamma: one code off
      if ($urandom_range(0, 1) == 1)
        rec = particle_item(cap_cfg, {1'b0, gam_cfg} ^ 16'(1 << $urandom_range(0, 15)),
                            stamp, energy_draw());
      else
        rec = particle_item(8'($urandom_range(0, 255)), {1'b0, gam_cfg}, stamp,
                            energy_draw());
    end else begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      rec   = noise[$bits(in_item_t)-1:0];
    end
    if (rec.command == CMD_ADD) begin
      recent_stamps = {recent_stamps, rec.hit_time};
      if (recent_stamps.size() > 16) void'(recent_stamps.pop_front());
    end
    return rec;
  endfunction

  task automatic push_item(in_item_t rec);
    particle_queue = {particle_queue, rec};
    items_queued++;
  endtask

  task automatic write_register(logic [2:0] idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_WINDOW:   win_cfg = value;
      CFG_CAPTURE:  cap_cfg = value[7:0];
      CFG_DECAY:    dec_cfg = value[7:0];
      CFG_GAMMA:    gam_cfg = value[14:0];
      CFG_ELECTRON: ele_cfg = value[14:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Every transaction yields exactly one report; wait for all, then let the block settle
  task automatic drain();
    while (reports_seen < items_queued) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned count, int unsigned clear_pm);
    gen_base = {8'($urandom_range(0, 255)), 32'($urandom)};
    gen_span = 8 * 32'(win_cfg) + 64;
    recent_stamps.delete();
    repeat (count) push_item(random_item(clear_pm));
  endtask

  initial begin
    in_item_t rec;
    int       n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on reset settings
    push_item(command_item(CMD_READ, 6'd0));
    push_item(command_item(CMD_NONE, 6'd0));
    push_item(command_item(CMD_CLEAR, 6'd0));
    rec = particle_item(cap_cfg, {1'b0, gam_cfg}, 40'd1000, 24'hFFFFF0);
    rec.pos_x = 16'h8000;
    rec.pos_y = 16'h7FFF;
    rec.pos_z = 16'h0000;
    push_item(rec);
    push_item(particle_item(cap_cfg, {1'b0, gam_cfg}, 40'd1009, 24'h000020));
    push_item(particle_item(cap_cfg, {1'b0, gam_cfg}, 40'd1010, 24'd5));
    push_item(particle_item(cap_cfg, {1'b0, gam_cfg}, 40'd1005, 24'd7));
    push_item(particle_item(dec_cfg, {1'b0, ele_cfg}, 40'd1003, 24'd100));
    push_item(particle_item(dec_cfg, 16'd0 - {1'b0, ele_cfg}, 40'd2000, 24'd200));
    push_item(particle_item(cap_cfg, {1'b0, gam_cfg}, 40'd1004, 24'd9));
    push_item(particle_item(cap_cfg, 16'd0 - {1'b0, gam_cfg}, 40'd1004, 24'd9));
    push_item(particle_item(dec_cfg, {1'b0, gam_cfg}, 40'd1004, 24'd9));
    push_item(particle_item(cap_cfg, {1'b0, ele_cfg}, 40'd1004, 24'd9));
    push_item(particle_item(dec_cfg, 16'h8000, 40'd1004, 24'd9));
    rec = particle_item(cap_cfg, {1'b0, gam_cfg}, 40'hFFFFFFFFFF, 24'hFFFFFF);
    rec.pos_x = 16'h7FFF;
    rec.pos_y = 16'h8000;
    rec.pos_z = 16'hFFFF;
    push_item(rec);
    push_item(particle_item(cap_cfg, {1'b0, gam_cfg}, 40'hFFFFFFFFF6, 24'd1));
    push_item(particle_item(cap_cfg, {1'b0, gam_cfg}, 40'd0, 24'd0));
    push_item(command_item(CMD_READ, 6'd0));
    push_item(command_item(CMD_READ, 6'd2));
    push_item(command_item(CMD_READ, 6'd5));
    push_item(command_item(CMD_READ, 6'd6));
    push_item(command_item(CMD_READ, 6'd63));
    push_item(command_item(CMD_CLEAR, 6'd0));
    push_item(command_item(CMD_READ, 6'd0));
    push_item(particle_item(dec_cfg, {1'b0, ele_cfg}, 40'd30000, 24'd50));
    drain();

    // Zero window: every gamma appends until the table overflows
    write_register(CFG_WINDOW, 16'd0);
    for (n = 0; n < 66; n++)
      push_item(particle_item(cap_cfg, {1'b0, gam_cfg}, 40'($urandom_range(0, 50000)),
                              energy_draw()));
    push_item(particle_item(dec_cfg, {1'b0, ele_cfg}, 40'd123, 24'd1));
    push_item(command_item(CMD_READ, 6'd63));
    push_item(command_item(CMD_READ, 6'd0));
    drain();

    // Widest window over a full table: merge into all entries
    write_register(CFG_WINDOW, 16'hFFFF);
    push_item(particle_item(cap_cfg, {1'b0, gam_cfg}, 40'd25000, 24'd3));
    push_item(particle_item(cap_cfg, {1'b0, gam_cfg}, 40'd24000, 24'hFFFFFF));
    push_item(particle_item(cap_cfg, {1'b0, gam_cfg}, 40'd26000, 24'd0));
    push_item(particle_item(dec_cfg, 16'd0 - {1'b0, ele_cfg}, 40'd26000, 24'd0));
    push_item(command_item(CMD_CLEAR, 6'd0));
    random_phase(130, 20);
    drain();

    write_register(CFG_CAPTURE, 16'd0);
    write_register(CFG_DECAY, 16'd255);
    write_register(CFG_GAMMA, 16'd0);
    write_register(CFG_ELECTRON, 16'd0);
    write_register(CFG_WINDOW, 16'd100);
    random_phase(130, 30);
    hold_req++;
    drain();

    // Top codes; the most negative particle code never matches an electron
    write_register(CFG_CAPTURE, 16'd255);
    write_register(CFG_DECAY, 16'd0);
    write_register(CFG_GAMMA, 16'h7FFF);
    write_register(CFG_ELECTRON, 16'h7FFF);
    write_register(CFG_WINDOW, 16'd1);
    push_item(particle_item(dec_cfg, 16'h8000, 40'd77, 24'd1));
    push_item(particle_item(dec_cfg, 16'h8001, 40'd78, 24'd2));
    push_item(particle_item(dec_cfg, 16'h7FFF, 40'd79, 24'd3));
    push_item(particle_item(cap_cfg, 16'h7FFF, 40'd78, 24'd4));
    random_phase(130, 0);
    drain();

    // Same interaction and code for both kinds: the gamma test wins
    write_register(CFG_CAPTURE, 16'd18);
    write_register(CFG_DECAY, 16'd18);
    write_register(CFG_GAMMA, 16'd22);
    write_register(CFG_ELECTRON, 16'd22);
    write_register(CFG_WINDOW, 16'd500);
    push_item(particle_item(8'd18, 16'd22, 40'd5000, 24'd1));
    push_item(particle_item(8'd18, 16'hFFEA, 40'd5000, 24'd1));
    random_phase(130, 20);
    drain();

    for (n = 0; n < 4; n++) begin
      write_register(CFG_WINDOW, ($urandom_range(0, 1) == 1) ?
                     16'($urandom_range(1, 2000)) : 16'($urandom));
      write_register(CFG_CAPTURE, 16'($urandom_range(0, 255)));
      write_register(CFG_DECAY, 16'($urandom_range(0, 255)));
      write_register(CFG_GAMMA, 16'($urandom_range(0, 32767)));
      write_register(CFG_ELECTRON, 16'($urandom_range(0, 32767)));
      random_phase(130, $urandom_range(0, 40));
      if (n == 2) hold_req++;
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Sender: predict on acceptance, then idle a drawn number of cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) begin
          report_queue = {report_queue, table_update(in_data_i)};
          if (send_calm > 0) begin
            send_calm--;
            send_wait = 0;
          end else begin
            send_wait = $urandom_range(0, 14);
            if ($urandom_range(0, 24) == 0) send_calm = $urandom_range(8, 40);
          end
        end
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (particle_queue.size() > 0) begin
          in_data_i  <= particle_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each report with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        reports_seen++;
        if (report_queue.size() == 0) begin
          fault_count++;
          if (fault_count <= PRINT_CAP)
            $display("%0t report with none pending: actual %p", $time, out_data_o);
        end else begin
          head_report = report_queue.pop_front();
          field_check("status", 64'(head_report.status), 64'(out_data_o.status));
          field_check("entry_slot", 64'(head_report.entry_slot), 64'(out_data_o.entry_slot));
          field_check("match_count", 64'(head_report.match_count),
                      64'(out_data_o.match_count));
          field_check("entry_kind", 64'(head_report.entry_kind), 64'(out_data_o.entry_kind));
          field_check("entry_time", 64'(head_report.entry_time), 64'(out_data_o.entry_time));
          field_check("entry_energy", 64'(head_report.entry_energy),
                      64'(out_data_o.entry_energy));
          field_check("entry_x", 64'(head_report.entry_x), 64'(out_data_o.entry_x));
          field_check("entry_y", 64'(head_report.entry_y), 64'(out_data_o.entry_y));
          field_check("entry_z", 64'(head_report.entry_z), 64'(out_data_o.entry_z));
          field_check("entry_total", 64'(head_report.entry_total),
                      64'(out_data_o.entry_total));
        end
        if (recv_calm > 0) begin
          recv_calm--;
          recv_wait = 0;
        end else begin
          recv_wait = $urandom_range(0, 14);
          if ($urandom_range(0, 24) == 0) recv_calm = $urandom_range(8, 40);
        end
      end
      // long hold-off so the block backs up into its input
      if (hold_seen != hold_req) begin
        hold_seen++;
        recv_hold = HOLD_CYCLES;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready_i <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

[sim.f]
sv/ctm_pkg.sv
sv/ctm_mem.sv
sv/ctm_match.sv
sv/time_coincidence_merge_table.sv
sv/ctm_checker.sv
dv/tb.sv
